// ===== rtl/bdq_pkg.sv =====
// Shared types and codes for the bounded deque with keyed removal.
// Used by the channel interfaces, the storage cell and the top level.
package bdq_pkg;

	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_FIND       = 3'd4,
		CMD_REMOVE     = 3'd5,
		CMD_READ_OUT   = 3'd6,
		CMD_CLEAR      = 3'd7
	} cmd_t;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// What every cell of the chain does at a clock edge.
	typedef enum logic [2:0] {
		OP_HOLD  = 3'd0,
		OP_LOAD  = 3'd1,
		OP_SHR   = 3'd2,
		OP_SHL   = 3'd3,
		OP_ROT   = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctl_t;

endpackage

// ===== rtl/bdq_req_if.sv =====
// Command channel of the deque: valid/ready handshake plus the command payload.
// Depends on bdq_pkg for the command width.
interface bdq_req_if #(
	parameter int DATA_W = 32,
	parameter int CNT_W  = 5
);
	logic                       valid;
	logic                       ready;
	logic [bdq_pkg::CMD_W-1:0]  command;
	logic [DATA_W-1:0]          value;
	logic [DATA_W-1:0]          key;
	logic [CNT_W-1:0]           limit;

	modport source (output valid, command, value, key, limit, input ready);
	modport sink   (input valid, command, value, key, limit, output ready);
endinterface

// ===== rtl/bdq_rsp_if.sv =====
// Result channel of the deque: valid/ready handshake plus the result payload.
// Depends on bdq_pkg for the status width.
interface bdq_rsp_if #(
	parameter int DATA_W = 32,
	parameter int CNT_W  = 5
);
	logic                          valid;
	logic                          ready;
	logic [DATA_W-1:0]             result_value;
	logic [bdq_pkg::STATUS_W-1:0]  status;
	logic [CNT_W-1:0]              entry_count;
	logic                          last;

	modport source (output valid, result_value, status, entry_count, last, input ready);
	modport sink   (input valid, result_value, status, entry_count, last, output ready);
endinterface

// ===== rtl/bdq_cell.sv =====
// One storage cell of the deque chain; holds the entry at its position from the front.
// Depends on bdq_pkg for the cell control struct.
module bdq_cell #(
	parameter int DATA_W = 32,
	parameter int CNT_W  = 5,
	parameter int IDX    = 0
) (
	input  logic                clk,
	input  bdq_pkg::cell_ctl_t  ctl,
	input  logic [CNT_W-1:0]    bound,
	input  logic [DATA_W-1:0]   fill,
	input  logic [DATA_W-1:0]   head,
	input  logic [DATA_W-1:0]   left,
	input  logic [DATA_W-1:0]   right,
	output logic [DATA_W-1:0]   data
);
	localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			bdq_pkg::OP_LOAD: begin
				if (POS == bound) data_q <= fill;
			end
			bdq_pkg::OP_SHR: data_q <= left;
			bdq_pkg::OP_SHL: data_q <= right;
			bdq_pkg::OP_ROT: begin
				// The front entry wraps to the end of the ring; the other ring entries move one place toward the front.
				if (POS == bound) data_q <= head;
				else if (POS < bound) data_q <= right;
			end
			default: ;
		endcase
	end

	assign data = data_q;

endmodule

// ===== rtl/bounded_deque_with_key_remove_unit.sv =====
// Top level of the bounded deque with find, keyed removal and read out.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if and bdq_cell.
//
// Entries live in a chain of DEPTH cells, front entry in cell 0. Pushes, pops and clear each
// give one result. Find, remove and read out rotate the stored entries once through cell 0,
// where a single comparator looks at the key, one stored entry per walk step, and the next
// command is taken only after the walk has passed every stored entry. Read out gives one
// result per entry up to its limit but still walks every stored entry, and a walk step that
// must give a result waits while the output register is still held. Results pass through
// one output register, so a command is accepted in the same cycle its predecessor's last
// result is taken.
module bounded_deque_with_key_remove_unit #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	bdq_req_if.sink    request,
	bdq_rsp_if.source  response
);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              step_q;
	logic [CNT_W-1:0]              len_q;
	logic [CNT_W-1:0]              nrd_q;
	logic                          hit_q;
	bdq_pkg::cmd_t                 cmd_q;
	logic [DATA_W-1:0]             key_q;
	logic [DATA_W-1:0]             found_q;

	logic                          out_valid_q;
	logic [DATA_W-1:0]             out_value_q;
	logic [bdq_pkg::STATUS_W-1:0]  out_status_q;
	logic [CNT_W-1:0]              out_count_q;
	logic                          out_last_q;

	logic [DATA_W-1:0]             cell_q   [DEPTH];
	logic [DATA_W-1:0]             chain_l  [DEPTH];
	logic [DATA_W-1:0]             chain_r  [DEPTH];

	bdq_pkg::cmd_t                 cmd;
	bdq_pkg::cell_ctl_t            ctl;
	logic [CNT_W-1:0]              bound;
	logic [DATA_W-1:0]             head;
	logic [DATA_W-1:0]             back_word;
	logic [CNT_W-1:0]              cnt_m1;
	logic [CNT_W-1:0]              nrd;
	logic                          accept;
	logic                          out_free;
	logic                          match;
	logic                          last_step;
	logic                          readout_emit;
	logic                          need_emit;
	logic                          go;
	logic                          drop;
	logic                          is_full;
	logic                          is_empty;

	logic                          emit;
	logic [DATA_W-1:0]             e_value;
	logic [bdq_pkg::STATUS_W-1:0]  e_status;
	logic [CNT_W-1:0]              e_count;
	logic                          e_last;

	// Cell chain.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign chain_l[g] = request.value;
		end else begin : g_mid_l
			assign chain_l[g] = cell_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign chain_r[g] = cell_q[g];
		end else begin : g_mid_r
			assign chain_r[g] = cell_q[g+1];
		end

		bdq_cell #(
			.DATA_W (DATA_W),
			.CNT_W  (CNT_W),
			.IDX    (g)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.bound (bound),
			.fill  (request.value),
			.head  (head),
			.left  (chain_l[g]),
			.right (chain_r[g]),
			.data  (cell_q[g])
		);
	end

	assign cmd       = bdq_pkg::cmd_t'(request.command);
	assign head      = cell_q[0];
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign back_word = cell_q[cnt_m1[IDX_W-1:0]];
	assign nrd       = (request.limit < cnt_q) ? request.limit : cnt_q;
	assign is_full   = (cnt_q == CNT_W'(DEPTH));
	assign is_empty  = (cnt_q == '0);

	assign out_free      = !out_valid_q || response.ready;
	assign request.ready = (state_q == S_IDLE) && out_free;
	assign accept        = request.valid && request.ready;

	assign match        = (head == key_q);
	assign last_step    = (step_q == cnt_m1);
	assign readout_emit = (cmd_q == bdq_pkg::CMD_READ_OUT) && (step_q < nrd_q);
	assign need_emit    = readout_emit || (last_step && cmd_q != bdq_pkg::CMD_READ_OUT);
	assign go           = (state_q == S_WALK) && (!need_emit || out_free);
	assign drop         = go && (cmd_q == bdq_pkg::CMD_REMOVE) && match && !hit_q;

	always_comb begin
		ctl.op   = bdq_pkg::OP_HOLD;
		bound    = cnt_q;
		emit     = 1'b0;
		e_value  = '0;
		e_status = bdq_pkg::STATUS_OK;
		e_count  = cnt_q;
		e_last   = 1'b1;
		if (accept) begin
			unique case (cmd)
				bdq_pkg::CMD_PUSH_BACK, bdq_pkg::CMD_PUSH_FRONT: begin
					emit = 1'b1;
					if (is_full) begin
						e_status = bdq_pkg::STATUS_FULL;
					end else begin
						ctl.op  = (cmd == bdq_pkg::CMD_PUSH_BACK) ? bdq_pkg::OP_LOAD
						                                          : bdq_pkg::OP_SHR;
						e_count = cnt_q + CNT_W'(1);
					end
				end
				bdq_pkg::CMD_POP_BACK, bdq_pkg::CMD_POP_FRONT: begin
					emit = 1'b1;
					if (is_empty) begin
						e_status = bdq_pkg::STATUS_EMPTY;
					end else begin
						e_count = cnt_m1;
						if (cmd == bdq_pkg::CMD_POP_BACK) begin
							e_value = back_word;
						end else begin
							e_value = head;
							ctl.op  = bdq_pkg::OP_SHL;
						end
					end
				end
				bdq_pkg::CMD_FIND, bdq_pkg::CMD_REMOVE: begin
					if (is_empty) begin
						emit     = 1'b1;
						e_status = bdq_pkg::STATUS_EMPTY;
					end
				end
				bdq_pkg::CMD_READ_OUT: begin
					if (nrd == '0) begin
						emit     = 1'b1;
						e_status = bdq_pkg::STATUS_EMPTY;
					end
				end
				bdq_pkg::CMD_CLEAR: begin
					emit    = 1'b1;
					e_count = '0;
				end
				default: ;
			endcase
		end else if (go) begin
			// Removing the matched entry shortens the ring; the rest keeps rotating.
			ctl.op = drop ? bdq_pkg::OP_SHL : bdq_pkg::OP_ROT;
			bound  = len_q - CNT_W'(1);
			if (readout_emit) begin
				emit    = 1'b1;
				e_value = head;
				e_last  = (step_q == nrd_q - CNT_W'(1));
			end else if (last_step && cmd_q != bdq_pkg::CMD_READ_OUT) begin
				emit     = 1'b1;
				e_status = (hit_q || match) ? bdq_pkg::STATUS_OK : bdq_pkg::STATUS_EMPTY;
				if (cmd_q == bdq_pkg::CMD_FIND) begin
					if (hit_q) e_value = found_q;
					else if (match) e_value = head;
				end else if (hit_q || match) begin
					e_count = cnt_m1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			step_q      <= '0;
			len_q       <= '0;
			nrd_q       <= '0;
			hit_q       <= 1'b0;
			cmd_q       <= bdq_pkg::CMD_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				cnt_q       <= e_count;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				cmd_q  <= cmd;
				nrd_q  <= nrd;
				step_q <= '0;
				len_q  <= cnt_q;
				hit_q  <= 1'b0;
				if (((cmd == bdq_pkg::CMD_FIND || cmd == bdq_pkg::CMD_REMOVE) && !is_empty)
				    || (cmd == bdq_pkg::CMD_READ_OUT && nrd != '0)) begin
					state_q <= S_WALK;
				end
			end else if (go) begin
				step_q <= step_q + CNT_W'(1);
				if (drop) len_q <= len_q - CNT_W'(1);
				if (match) hit_q <= 1'b1;
				if (last_step) state_q <= S_IDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) key_q <= request.key;
		if (go && match && !hit_q) found_q <= head;
		if (emit) begin
			out_value_q  <= e_value;
			out_status_q <= e_status;
			out_count_q  <= e_count;
			out_last_q   <= e_last;
		end
	end

	assign response.valid        = out_valid_q;
	assign response.result_value = out_value_q;
	assign response.status       = out_status_q;
	assign response.entry_count  = out_count_q;
	assign response.last         = out_last_q;

	// Commands are only taken between walks.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == S_IDLE)
		else $error("command transfer during a walk");

	// The ring length only drops below the stored count after a removal hit.
	a_ring_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> (len_q == cnt_q)
			|| (cmd_q == bdq_pkg::CMD_REMOVE && hit_q && len_q == cnt_m1))
		else $error("ring length out of step with entry count");

	// A clear leaves the store empty.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == bdq_pkg::CMD_CLEAR) |=> cnt_q == '0)
		else $error("clear left entries behind");

	// The count never passes capacity.
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> e_count <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

endmodule
